FILE: rtl/core/frma_pkg.sv
// Package: widths, defaults and reset values shared by the frame rate meter.
`default_nettype none

package frma_pkg;

    // Fixed field widths
    localparam int TICK_W  = 32;   // timestamp and wrapped difference
    localparam int RATE_W  = 20;   // tick rate register and per-frame rate
    localparam int S_DATA_W = ((TICK_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((RATE_W + 7) / 8) * 8;

    // Defaults
    localparam int WINDOW_DEF = 50;
    localparam logic [RATE_W-1:0] TICK_RATE_RST = RATE_W'(1000);

endpackage

`default_nettype wire

FILE: rtl/core/frame_rate_moving_average.sv
// Top level: moving-average frame rate meter with a shared bit-serial divider.
`default_nettype none

// Channel   Dir  Handshake          Payload
// --------  ---  -----------------  ----------------------------------------
// slave     in   s_tvalid/s_tready  s_tdata[31:0]  tick_now
// master    out  m_tvalid/m_tready  m_tdata[19:0]  frames_per_second
// config    in   cfg_valid/cfg_ready cfg_data[19:0] tick_rate_hz
//
// Divider: a word's result comes from the single restoring divider, one
// quotient bit per cycle: first the tick rate over the timestamp difference
// (skipped when the timestamp equals the last one, giving a rate of zero),
// then the window total over the fill count. The next word is taken only
// after the result of the last one has been raised.
// Reset: asynchronous, active low; clears control, total, index and count.
// The ring holds no reset: a slot's old value is used only once the window
// is full, after every slot has been written. No clearing pass is needed.
// Stalls: s_tready is high in idle only; a held result in the output
// register does not block the next word until a new result is ready.

module frame_rate_moving_average
    import frma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // slave stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,    // [31:0] tick_now
    // master stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,    // [19:0] frames_per_second, rest zero
    // configuration write
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [RATE_W-1:0]    cfg_data    // [19:0] tick_rate_hz
);

    // Derived widths
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int TOT_W  = RATE_W + $clog2(WINDOW);   // holds WINDOW * (2^RATE_W - 1)
    localparam int REM_W  = ((RATE_W > CNT_W) ? RATE_W : CNT_W) + 1;
    localparam int STEP_W = $clog2(TOT_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV1,
        S_UPD,
        S_DIV2,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [RATE_W-1:0]    tick_rate_reg;
    logic [TICK_W-1:0]    now_reg;
    logic [TICK_W-1:0]    last_reg;
    logic [RATE_W-1:0]    old_reg;        // slot value being overwritten
    logic [TOT_W-1:0]     total_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [TOT_W-1:0]     dvd_reg;        // dividend in, quotient out
    logic [REM_W-1:0]     rem_reg;
    logic [TICK_W-1:0]    dsr_reg;        // divisor
    logic                 out_valid_reg;
    logic [RATE_W-1:0]    out_data_reg;

    logic [RATE_W-1:0]    ring [WINDOW];

    logic                 in_accept;
    logic                 ring_we;
    logic [REM_W-1:0]     trial;
    logic                 ge;
    logic [REM_W-1:0]     rem_step;
    logic [TOT_W-1:0]     dvd_step;
    logic [TOT_W-1:0]     total_sum;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_DATA_W'(out_data_reg);
    assign ring_we   = (state_reg == S_UPD);

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg[REM_W-2:0], dvd_reg[TOT_W-1]};
        ge       = ({{(TICK_W-REM_W){1'b0}}, trial} >= dsr_reg);
        rem_step = ge ? (trial - dsr_reg[REM_W-1:0]) : trial;
        dvd_step = {dvd_reg[TOT_W-2:0], ge};
        total_sum = total_reg + TOT_W'(dvd_reg[RATE_W-1:0]);
    end

    // Rate ring: read the slot on acceptance, write it back once the rate is known
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[slot_reg] <= dvd_reg[RATE_W-1:0];
        end
        if (in_accept)
        begin
            old_reg <= ring[slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_rate_reg <= TICK_RATE_RST;
            now_reg       <= '0;
            last_reg      <= '0;
            total_reg     <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            step_reg      <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            dsr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // The user must write only while idle; the block itself does not enforce it
            if (cfg_valid && cfg_ready)
            begin
                tick_rate_reg <= cfg_data;
            end

            // Drop the result once taken; the final state reloads it itself
            if (out_valid_reg && m_tready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        now_reg   <= s_tdata[TICK_W-1:0];
                        state_reg <= S_PREP;
                    end
                end

                S_PREP:
                begin
                    // Retire the oldest slot once the window is full, else grow
                    if (fill_reg == CNT_W'(WINDOW))
                    begin
                        total_reg <= total_reg - TOT_W'(old_reg);
                    end
                    else
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end

                    if (now_reg != last_reg)
                    begin
                        dsr_reg   <= now_reg - last_reg;
                        dvd_reg   <= TOT_W'(tick_rate_reg) << (TOT_W - RATE_W);
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        last_reg  <= now_reg;
                        state_reg <= S_DIV1;
                    end
                    else
                    begin
                        // Equal timestamps: rate of zero
                        dvd_reg   <= '0;
                        state_reg <= S_UPD;
                    end
                end

                S_DIV1:
                begin
                    rem_reg  <= rem_step;
                    dvd_reg  <= dvd_step;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(RATE_W - 1))
                    begin
                        state_reg <= S_UPD;
                    end
                end

                S_UPD:
                begin
                    // Rate sits in the low bits of the dividend register
                    total_reg <= total_sum;
                    slot_reg  <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                    dvd_reg   <= total_sum;
                    dsr_reg   <= TICK_W'(fill_reg);
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV2;
                end

                S_DIV2:
                begin
                    rem_reg  <= rem_step;
                    dvd_reg  <= dvd_step;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(TOT_W - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    // Hold until the output register is free
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= dvd_reg[RATE_W-1:0];
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Fill count never passes the window
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    // Slot index stays inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("slot index beyond ring");

    // Until the window fills, the slot index tracks the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && (fill_reg != CNT_W'(WINDOW))
            |-> (CNT_W'(slot_reg) == fill_reg))
        else $error("slot index out of step with fill count");

    // A new result is only raised from the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside final state");

endmodule

`default_nettype wire
